// File: hdl/baro_pressure_temp_compensation_macros.svh
// assertion macros for the barometric compensation block
// used by the pipeline control; expects clk and arst_n in scope
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_MACROS_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_MACROS_SVH

// checked only outside reset
`define BPTC_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("bptc pipeline check failed");

// checked at every edge, reset included
`define BPTC_ASSERT_RST(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("bptc pipeline check failed around reset");

`endif

// File: hdl/bptc_pkg.sv
// shared types and constants of the barometric compensation block
// no dependencies; used by every module under hdl
package bptc_pkg;

	// ports and register file
	localparam int RAW_PORT_W = 24;
	localparam int CAL_W      = 16;
	localparam int DATA_W     = 32;
	localparam int ADDR_W     = 5;
	localparam int ADDR_LSB   = 2;
	localparam int IDX_W      = ADDR_W - ADDR_LSB;

	// pipeline shape
	localparam int TEMP_STAGES  = 6;
	localparam int PRESS_STAGES = 3;
	localparam int PIPE_DEPTH   = TEMP_STAGES + PRESS_STAGES;

	// datapath widths
	localparam int DT_W    = 25;
	localparam int PF_W    = DT_W + CAL_W + 1;
	localparam int MUL_W   = 41;
	localparam int DD_W    = 48;
	localparam int T2_SHIFT = 31;
	localparam int T2_W    = DD_W - T2_SHIFT;
	localparam int TQ_W    = 18;
	localparam int CQ_W    = TQ_W + 1;
	localparam int SQ_W    = 34;
	localparam int TEMP_W  = 20;
	localparam int OFF_W   = 35;
	localparam int SENS_W  = 34;
	localparam int CORR_W  = 38;
	localparam int OFFF_W  = 40;
	localparam int SENSF_W = 39;
	localparam int SPLIT_W = 20;
	localparam int HI_W    = SENSF_W - SPLIT_W;
	localparam int PRES_W  = 32;

	// scaling
	localparam int C5_SHIFT        = 8;
	localparam int OFF_BASE_SHIFT  = 16;
	localparam int SENS_BASE_SHIFT = 15;
	localparam int OFF_SHIFT       = 7;
	localparam int SENS_SHIFT      = 8;
	localparam int TDIV_SHIFT      = 23;
	localparam int TDIV_BIAS       = (2 ** TDIV_SHIFT) - 1;
	localparam int TEMP_BASE       = 2000;
	localparam int COLD_OFS        = 3500;
	localparam int P_SHIFT         = 21;
	localparam int PRES_SHIFT      = 15;

	typedef enum logic [IDX_W-1:0] {
		REG_C1 = 3'd0,
		REG_C2 = 3'd1,
		REG_C3 = 3'd2,
		REG_C4 = 3'd3,
		REG_C5 = 3'd4,
		REG_C6 = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [CAL_W-1:0] c1;
		logic [CAL_W-1:0] c2;
		logic [CAL_W-1:0] c3;
		logic [CAL_W-1:0] c4;
		logic [CAL_W-1:0] c5;
		logic [CAL_W-1:0] c6;
	} cal_t;

	// handoff from the temperature half to the pressure half
	typedef struct packed {
		logic                      zero;
		logic signed [TEMP_W-1:0]  temp;
		logic signed [OFFF_W-1:0]  off;
		logic signed [SENSF_W-1:0] sens;
	} mid_t;

endpackage

// File: hdl/bptc_cfg_regs.sv
// apb register file for the six calibration words
// depends on bptc_pkg
module bptc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bptc_pkg::ADDR_W-1:0]    paddr,
	input  logic [bptc_pkg::DATA_W-1:0]    pwdata,
	output logic [bptc_pkg::DATA_W-1:0]    prdata,
	output logic                           pready,
	output bptc_pkg::cal_t                 cal
);

	bptc_pkg::cal_t   cal_q;
	bptc_pkg::reg_idx_t idx;
	logic             wr_en;
	logic [bptc_pkg::CAL_W-1:0] wdata;

	assign pready = 1'b1;
	assign idx    = bptc_pkg::reg_idx_t'(paddr[bptc_pkg::ADDR_W-1:bptc_pkg::ADDR_LSB]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign wdata  = pwdata[bptc_pkg::CAL_W-1:0];
	assign cal    = cal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				bptc_pkg::REG_C1: cal_q.c1 <= wdata;
				bptc_pkg::REG_C2: cal_q.c2 <= wdata;
				bptc_pkg::REG_C3: cal_q.c3 <= wdata;
				bptc_pkg::REG_C4: cal_q.c4 <= wdata;
				bptc_pkg::REG_C5: cal_q.c5 <= wdata;
				bptc_pkg::REG_C6: cal_q.c6 <= wdata;
				default: ; // addresses past the last word are ignored
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			bptc_pkg::REG_C1: prdata = bptc_pkg::DATA_W'(cal_q.c1);
			bptc_pkg::REG_C2: prdata = bptc_pkg::DATA_W'(cal_q.c2);
			bptc_pkg::REG_C3: prdata = bptc_pkg::DATA_W'(cal_q.c3);
			bptc_pkg::REG_C4: prdata = bptc_pkg::DATA_W'(cal_q.c4);
			bptc_pkg::REG_C5: prdata = bptc_pkg::DATA_W'(cal_q.c5);
			bptc_pkg::REG_C6: prdata = bptc_pkg::DATA_W'(cal_q.c6);
			default:          prdata = '0;
		endcase
	end

endmodule

// File: hdl/bptc_pipe_ctrl.sv
// valid bits and per-stage advance enables for the compensation pipeline
// depends on bptc_pkg and baro_pressure_temp_compensation_macros.svh
`include "baro_pressure_temp_compensation_macros.svh"

module bptc_pipe_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              sample_valid,
	output logic                              sample_ready,
	output logic                              result_valid,
	input  logic                              result_ready,
	output logic [bptc_pkg::PIPE_DEPTH-1:0]   stage_en
);

	localparam int LAST = bptc_pkg::PIPE_DEPTH - 1;

	logic [bptc_pkg::PIPE_DEPTH-1:0] valid_q;
	logic accept_in;
	logic accept_out;

	// a stage moves when it is empty or the stage after it moves
	assign stage_en[LAST] = !valid_q[LAST] || result_ready;
	for (genvar k = 0; k < LAST; k++) begin : g_en
		assign stage_en[k] = !valid_q[k] || stage_en[k+1];
	end

	assign sample_ready = stage_en[0];
	assign result_valid = valid_q[LAST];
	assign accept_in    = sample_valid && sample_ready;
	assign accept_out   = result_valid && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (stage_en[0]) begin
				valid_q[0] <= sample_valid;
			end
			for (int k = 1; k <= LAST; k++) begin
				if (stage_en[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	// input only backs up when every stage holds a transaction
	`BPTC_ASSERT(a_full_when_blocked, !sample_ready |-> (&valid_q))
	// a ready sink lets every stage move
	`BPTC_ASSERT(a_ready_opens_all, result_ready |-> (&stage_en))
	// transactions are neither lost nor duplicated inside the pipe
	`BPTC_ASSERT(a_occupancy, $past(arst_n) |-> ($countones(valid_q) == $past($countones(valid_q)) + $past(accept_in) - $past(accept_out)))
	`BPTC_ASSERT_RST(a_reset_empty, !arst_n |-> (valid_q == '0))

endmodule

// File: hdl/bptc_temp_path.sv
// stages 1 to 6: dT, first-order terms, second-order correction, temperature
// depends on bptc_pkg
module bptc_temp_path #(
	parameter int RAW_WIDTH = 24
) (
	input  logic                                clk,
	input  logic [bptc_pkg::TEMP_STAGES-1:0]    stage_en,
	input  bptc_pkg::cal_t                      cal,
	input  logic [bptc_pkg::RAW_PORT_W-1:0]     raw_pressure,
	input  logic [bptc_pkg::RAW_PORT_W-1:0]     raw_temperature,
	output logic [RAW_WIDTH-1:0]                d1,
	output bptc_pkg::mid_t                      mid
);

	localparam int DT_W    = bptc_pkg::DT_W;
	localparam int PF_W    = bptc_pkg::PF_W;
	localparam int MUL_W   = bptc_pkg::MUL_W;
	localparam int DD_W    = bptc_pkg::DD_W;
	localparam int T2_W    = bptc_pkg::T2_W;
	localparam int TQ_W    = bptc_pkg::TQ_W;
	localparam int CQ_W    = bptc_pkg::CQ_W;
	localparam int SQ_W    = bptc_pkg::SQ_W;
	localparam int TEMP_W  = bptc_pkg::TEMP_W;
	localparam int OFF_W   = bptc_pkg::OFF_W;
	localparam int SENS_W  = bptc_pkg::SENS_W;
	localparam int CORR_W  = bptc_pkg::CORR_W;
	localparam int OFFF_W  = bptc_pkg::OFFF_W;
	localparam int SENSF_W = bptc_pkg::SENSF_W;

	// stage 1
	logic [RAW_WIDTH-1:0]     d1_raw, d2_raw;
	logic signed [DT_W-1:0]   dt_d;
	logic [RAW_WIDTH-1:0]     d1_s1;
	logic                     zero_s1;
	logic signed [DT_W-1:0]   dt_s1;

	// stage 2
	logic signed [PF_W-1:0]   p6_f, p4_f, p3_f;
	logic signed [2*DT_W-1:0] dd_f;
	logic signed [MUL_W-1:0]  p6_s2, p4_s2, p3_s2;
	logic [DD_W-1:0]          dd_s2;
	logic [RAW_WIDTH-1:0]     d1_s2;
	logic                     zero_s2;

	// stage 3
	logic signed [MUL_W-1:0]  p6_b, p6_q, p4_q, p3_q;
	logic signed [TQ_W-1:0]   q_d;
	logic signed [OFF_W-1:0]  off_d;
	logic signed [SENS_W-1:0] sens_d;
	logic signed [TQ_W-1:0]   q_s3;
	logic signed [OFF_W-1:0]  off_s3;
	logic signed [SENS_W-1:0] sens_s3;
	logic [T2_W-1:0]          t2_s3;
	logic [RAW_WIDTH-1:0]     d1_s3;
	logic                     zero_s3;

	// stage 4
	logic signed [2*TQ_W-1:0] sq_f;
	logic signed [CQ_W-1:0]   cq_d;
	logic signed [2*CQ_W-1:0] csq_f;
	logic signed [TEMP_W-1:0] temp_d;
	logic [SQ_W-1:0]          sq_s4, csq_s4;
	logic                     warm_s4, cold_s4;
	logic signed [TEMP_W-1:0] temp_s4;
	logic signed [OFF_W-1:0]  off_s4;
	logic signed [SENS_W-1:0] sens_s4;
	logic [T2_W-1:0]          t2_s4;
	logic [RAW_WIDTH-1:0]     d1_s4;
	logic                     zero_s4;

	// stage 5
	logic [CORR_W-1:0]        sq_x, csq_x, five_x, seven_x, eleven_x, off2_d, sens2_d;
	logic signed [TEMP_W-1:0] temp5_d;
	logic [CORR_W-1:0]        off2_s5, sens2_s5;
	logic signed [TEMP_W-1:0] temp_s5;
	logic signed [OFF_W-1:0]  off_s5;
	logic signed [SENS_W-1:0] sens_s5;
	logic [RAW_WIDTH-1:0]     d1_s5;
	logic                     zero_s5;

	// stage 6
	logic signed [OFFF_W-1:0]  offf_d;
	logic signed [SENSF_W-1:0] sensf_d;
	logic signed [OFFF_W-1:0]  offf_s6;
	logic signed [SENSF_W-1:0] sensf_s6;
	logic signed [TEMP_W-1:0]  temp_s6;
	logic [RAW_WIDTH-1:0]      d1_s6;
	logic                      zero_s6;

	// stage 1: mask, zero check, dT
	assign d1_raw = raw_pressure[RAW_WIDTH-1:0];
	assign d2_raw = raw_temperature[RAW_WIDTH-1:0];
	assign dt_d   = signed'(DT_W'(d2_raw))
		- signed'(DT_W'({cal.c5, {bptc_pkg::C5_SHIFT{1'b0}}}));

	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			d1_s1   <= d1_raw;
			zero_s1 <= (d1_raw == '0) || (d2_raw == '0);
			dt_s1   <= dt_d;
		end
	end

	// stage 2: the four dT products
	assign p6_f = dt_s1 * signed'({1'b0, cal.c6});
	assign p4_f = dt_s1 * signed'({1'b0, cal.c4});
	assign p3_f = dt_s1 * signed'({1'b0, cal.c3});
	assign dd_f = dt_s1 * dt_s1;

	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			p6_s2   <= p6_f[MUL_W-1:0];
			p4_s2   <= p4_f[MUL_W-1:0];
			p3_s2   <= p3_f[MUL_W-1:0];
			dd_s2   <= dd_f[DD_W-1:0];
			d1_s2   <= d1_s1;
			zero_s2 <= zero_s1;
		end
	end

	// stage 3: truncating divide for TEMP, floor shifts for OFF and SENS
	assign p6_b   = p6_s2 + (p6_s2[MUL_W-1] ? MUL_W'(bptc_pkg::TDIV_BIAS) : '0);
	assign p6_q   = p6_b >>> bptc_pkg::TDIV_SHIFT;
	assign q_d    = p6_q[TQ_W-1:0];
	assign p4_q   = p4_s2 >>> bptc_pkg::OFF_SHIFT;
	assign p3_q   = p3_s2 >>> bptc_pkg::SENS_SHIFT;
	assign off_d  = signed'(p4_q[OFF_W-1:0])
		+ signed'(OFF_W'({cal.c2, {bptc_pkg::OFF_BASE_SHIFT{1'b0}}}));
	assign sens_d = signed'(p3_q[SENS_W-1:0])
		+ signed'(SENS_W'({cal.c1, {bptc_pkg::SENS_BASE_SHIFT{1'b0}}}));

	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			q_s3    <= q_d;
			off_s3  <= off_d;
			sens_s3 <= sens_d;
			t2_s3   <= dd_s2[DD_W-1:bptc_pkg::T2_SHIFT];
			d1_s3   <= d1_s2;
			zero_s3 <= zero_s2;
		end
	end

	// stage 4: q is TEMP-2000, cq is TEMP+1500
	assign sq_f   = q_s3 * q_s3;
	assign cq_d   = CQ_W'(q_s3) + CQ_W'(bptc_pkg::COLD_OFS);
	assign csq_f  = cq_d * cq_d;
	assign temp_d = TEMP_W'(q_s3) + TEMP_W'(bptc_pkg::TEMP_BASE);

	always_ff @(posedge clk) begin
		if (stage_en[3]) begin
			sq_s4   <= sq_f[SQ_W-1:0];
			csq_s4  <= csq_f[SQ_W-1:0];
			warm_s4 <= q_s3[TQ_W-1];
			cold_s4 <= cq_d[CQ_W-1];
			temp_s4 <= temp_d;
			off_s4  <= off_s3;
			sens_s4 <= sens_s3;
			t2_s4   <= t2_s3;
			d1_s4   <= d1_s3;
			zero_s4 <= zero_s3;
		end
	end

	// stage 5: OFF2 and SENS2 by shift-add, T2 taken off the temperature
	assign sq_x     = warm_s4 ? CORR_W'(sq_s4) : '0;
	assign csq_x    = cold_s4 ? CORR_W'(csq_s4) : '0;
	assign five_x   = (sq_x << 2) + sq_x;
	assign seven_x  = (csq_x << 3) - csq_x;
	assign eleven_x = (csq_x << 3) + (csq_x << 1) + csq_x;
	assign off2_d   = (five_x >> 1) + seven_x;
	assign sens2_d  = (five_x >> 2) + (eleven_x >> 1);
	assign temp5_d  = temp_s4 - (warm_s4 ? TEMP_W'(t2_s4) : '0);

	always_ff @(posedge clk) begin
		if (stage_en[4]) begin
			off2_s5  <= off2_d;
			sens2_s5 <= sens2_d;
			temp_s5  <= temp5_d;
			off_s5   <= off_s4;
			sens_s5  <= sens_s4;
			d1_s5    <= d1_s4;
			zero_s5  <= zero_s4;
		end
	end

	// stage 6: corrected OFF and SENS
	assign offf_d  = signed'(OFFF_W'(off_s5)) - signed'(OFFF_W'(off2_s5));
	assign sensf_d = signed'(SENSF_W'(sens_s5)) - signed'(SENSF_W'(sens2_s5));

	always_ff @(posedge clk) begin
		if (stage_en[5]) begin
			offf_s6  <= offf_d;
			sensf_s6 <= sensf_d;
			temp_s6  <= temp_s5;
			d1_s6    <= d1_s5;
			zero_s6  <= zero_s5;
		end
	end

	assign d1       = d1_s6;
	assign mid.zero = zero_s6;
	assign mid.temp = temp_s6;
	assign mid.off  = offf_s6;
	assign mid.sens = sensf_s6;

endmodule

// File: hdl/bptc_press_path.sv
// stages 7 to 9: D1 times SENS in two partial products, final pressure
// depends on bptc_pkg
module bptc_press_path #(
	parameter int RAW_WIDTH = 24
) (
	input  logic                                  clk,
	input  logic [bptc_pkg::PRESS_STAGES-1:0]     stage_en,
	input  logic [RAW_WIDTH-1:0]                  d1,
	input  bptc_pkg::mid_t                        mid,
	output logic signed [bptc_pkg::PRES_W-1:0]    pressure_centi_mbar,
	output logic signed [bptc_pkg::TEMP_W-1:0]    temperature_centi_c,
	output logic                                  status
);

	localparam int SPLIT_W = bptc_pkg::SPLIT_W;
	localparam int HI_W    = bptc_pkg::HI_W;
	localparam int OFFF_W  = bptc_pkg::OFFF_W;
	localparam int SENSF_W = bptc_pkg::SENSF_W;
	localparam int TEMP_W  = bptc_pkg::TEMP_W;
	localparam int PRES_W  = bptc_pkg::PRES_W;
	localparam int PL_W    = RAW_WIDTH + SPLIT_W;
	localparam int PH_W    = RAW_WIDTH + 1 + HI_W;
	localparam int PROD_W  = RAW_WIDTH + SENSF_W;
	localparam int SH_W    = PROD_W - bptc_pkg::P_SHIFT;
	localparam int XS_W    = ((SH_W > OFFF_W) ? SH_W : OFFF_W) + 1;

	// stage 7
	logic [SPLIT_W-1:0]       sens_lo;
	logic signed [HI_W-1:0]   sens_hi;
	logic [PL_W-1:0]          pl_d;
	logic signed [PH_W-1:0]   ph_d;
	logic [PL_W-1:0]          pl_s7;
	logic signed [PH_W-1:0]   ph_s7;
	logic signed [OFFF_W-1:0] offf_s7;
	logic signed [TEMP_W-1:0] temp_s7;
	logic                     zero_s7;

	// stage 8
	logic signed [PROD_W-1:0] ph_x, pl_x, prod_d;
	logic signed [PROD_W-1:0] prod_s8;
	logic signed [OFFF_W-1:0] offf_s8;
	logic signed [TEMP_W-1:0] temp_s8;
	logic                     zero_s8;

	// stage 9
	logic signed [PROD_W-1:0] sh_d;
	logic signed [XS_W-1:0]   x_d, pw_d;
	logic signed [PRES_W-1:0] pres_d;
	logic signed [PRES_W-1:0] pres_s9;
	logic signed [TEMP_W-1:0] temp_s9;
	logic                     status_s9;

	// stage 7: unsigned low slice and signed high slice of SENS
	assign sens_lo = mid.sens[SPLIT_W-1:0];
	assign sens_hi = mid.sens[SENSF_W-1:SPLIT_W];
	assign pl_d    = PL_W'(d1) * PL_W'(sens_lo);
	assign ph_d    = signed'({1'b0, d1}) * sens_hi;

	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			pl_s7   <= pl_d;
			ph_s7   <= ph_d;
			offf_s7 <= mid.off;
			temp_s7 <= mid.temp;
			zero_s7 <= mid.zero;
		end
	end

	// stage 8: recombine the partial products
	assign ph_x   = PROD_W'(ph_s7);
	assign pl_x   = signed'(PROD_W'(pl_s7));
	assign prod_d = (ph_x <<< SPLIT_W) + pl_x;

	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			prod_s8 <= prod_d;
			offf_s8 <= offf_s7;
			temp_s8 <= temp_s7;
			zero_s8 <= zero_s7;
		end
	end

	// stage 9: both floor shifts; the result always lies inside 32 bits signed
	assign sh_d   = prod_s8 >>> bptc_pkg::P_SHIFT;
	assign x_d    = XS_W'(sh_d) + XS_W'(offf_s8);
	assign pw_d   = x_d >>> bptc_pkg::PRES_SHIFT;
	assign pres_d = pw_d[PRES_W-1:0];

	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			pres_s9   <= zero_s8 ? '0 : pres_d;
			temp_s9   <= zero_s8 ? '0 : temp_s8;
			status_s9 <= zero_s8;
		end
	end

	assign pressure_centi_mbar = pres_s9;
	assign temperature_centi_c = temp_s9;
	assign status              = status_s9;

endmodule

// File: hdl/baro_pressure_temp_compensation.sv
// Compensated pressure and temperature from one raw conversion pair with
// second-order correction below 20 degC. One transaction enters per clock
// while sample_ready is high. Nine pipeline stages (dT, products,
// first-order terms, squares, correction terms, corrected offset and
// sensitivity, two partial products of D1 times SENS, recombination, final
// shifts) each hold at most one multiplier level. A result-side stall
// holds only full stages, so empty stages keep taking new transactions. A
// zero raw reading gives status 1 and zero outputs. The six calibration
// words sit on the APB port at byte addresses 0 to 20; the user must write
// them only while no transaction is in flight, not enforced by the block.
// depends on bptc_pkg, bptc_cfg_regs, bptc_pipe_ctrl, bptc_temp_path,
// bptc_press_path
module baro_pressure_temp_compensation #(
	parameter int RAW_WIDTH = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [bptc_pkg::ADDR_W-1:0]          paddr,
	input  logic [bptc_pkg::DATA_W-1:0]          pwdata,
	output logic [bptc_pkg::DATA_W-1:0]          prdata,
	output logic                                 pready,
	input  logic                                 sample_valid,
	output logic                                 sample_ready,
	input  logic [bptc_pkg::RAW_PORT_W-1:0]      raw_pressure,
	input  logic [bptc_pkg::RAW_PORT_W-1:0]      raw_temperature,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output logic signed [bptc_pkg::PRES_W-1:0]   pressure_centi_mbar,
	output logic signed [bptc_pkg::TEMP_W-1:0]   temperature_centi_c,
	output logic                                 status
);

	bptc_pkg::cal_t                  cal;
	bptc_pkg::mid_t                  mid;
	logic [RAW_WIDTH-1:0]            d1;
	logic [bptc_pkg::PIPE_DEPTH-1:0] stage_en;

	bptc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cal     (cal)
	);

	bptc_pipe_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.stage_en     (stage_en)
	);

	bptc_temp_path #(
		.RAW_WIDTH (RAW_WIDTH)
	) u_temp (
		.clk             (clk),
		.stage_en        (stage_en[bptc_pkg::TEMP_STAGES-1:0]),
		.cal             (cal),
		.raw_pressure    (raw_pressure),
		.raw_temperature (raw_temperature),
		.d1              (d1),
		.mid             (mid)
	);

	bptc_press_path #(
		.RAW_WIDTH (RAW_WIDTH)
	) u_press (
		.clk                 (clk),
		.stage_en            (stage_en[bptc_pkg::PIPE_DEPTH-1:bptc_pkg::TEMP_STAGES]),
		.d1                  (d1),
		.mid                 (mid),
		.pressure_centi_mbar (pressure_centi_mbar),
		.temperature_centi_c (temperature_centi_c),
		.status              (status)
	);

endmodule

// File: tb/tb_baro_pressure_temp_compensation.sv
`timescale 1ns / 100ps
// self-checking testbench for baro_pressure_temp_compensation: predicts each compensated reading
// and compares it with the block's results; depends on bptc_pkg and the block's hdl sources
module tb_baro_pressure_temp_compensation;
	import bptc_pkg::*;

	localparam int RAW_WIDTH = 24;
	localparam longint RAW_MASK = (longint'(1) << RAW_WIDTH) - 1;
	localparam longint RAW_MAX = (longint'(1) << RAW_PORT_W) - 1;
	localparam longint TEMP_REF = 2000;
	localparam longint COLD_LIMIT = -1500;
	localparam longint TDIV = 8388608;
	localparam longint PRES_MAX = 64'sd2147483647;
	localparam longint PRES_MIN = -64'sd2147483648;
	localparam logic [IDX_W-1:0] REG_SPARE0 = 3'd6;
	localparam logic [IDX_W-1:0] REG_SPARE1 = 3'd7;
	localparam int RANDOM_SETS = 8;
	localparam int SET_SAMPLES = 72;
	localparam int LONG_HOLD = 60;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic [RAW_PORT_W-1:0] d1;
		logic [RAW_PORT_W-1:0] d2;
	} sample_t;

	typedef struct packed {
		logic signed [PRES_W-1:0] pressure;
		logic signed [TEMP_W-1:0] temperature;
		logic                     status;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic sample_valid = 1'b0;
	logic sample_ready;
	logic [RAW_PORT_W-1:0] raw_pressure = '0;
	logic [RAW_PORT_W-1:0] raw_temperature = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic signed [PRES_W-1:0] pressure_centi_mbar;
	logic signed [TEMP_W-1:0] temperature_centi_c;
	logic status;

	cal_t cal = '0;
	sample_t pending_samples[$];
	reading_t expected_readings[$];
	sample_t next_sample;
	reading_t want, got;
	bit in_fire = 1'b0;
	bit out_fire = 1'b0;
	bit idle_enable = 1'b1;
	int src_gap = 0;
	int sink_gap = 0;
	int hold_request = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int errors = 0;
	int n_checked = 0;
	int n_zero = 0;
	int n_cold = 0;
	int n_cal_sets = 1;

	baro_pressure_temp_compensation #(.RAW_WIDTH(RAW_WIDTH)) uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.sample_valid(sample_valid), .sample_ready(sample_ready),
		.raw_pressure(raw_pressure), .raw_temperature(raw_temperature),
		.result_valid(result_valid), .result_ready(result_ready),
		.pressure_centi_mbar(pressure_centi_mbar),
		.temperature_centi_c(temperature_centi_c), .status(status)
	);

	always #2 clk = ~clk;

	function automatic reading_t compensate(input logic [RAW_PORT_W-1:0] d1_raw,
			input logic [RAW_PORT_W-1:0] d2_raw);
		longint d1, d2, dt, t, off, sens, t2, off2, sens2, dtemp, cold, p;
		reading_t r;
		d1 = longint'(d1_raw) & RAW_MASK;
		d2 = longint'(d2_raw) & RAW_MASK;
		r = '0;
		if (d1 == 0 || d2 == 0) begin
			r.status = 1'b1;
			return r;
		end
		dt = d2 - (longint'(cal.c5) << C5_SHIFT);
		// signed division truncates toward zero
		t = TEMP_REF + (dt * longint'(cal.c6)) / TDIV;
		off = (longint'(cal.c2) << OFF_BASE_SHIFT) + ((longint'(cal.c4) * dt) >>> OFF_SHIFT);
		sens = (longint'(cal.c1) << SENS_BASE_SHIFT) + ((longint'(cal.c3) * dt) >>> SENS_SHIFT);
		t2 = 0;
		off2 = 0;
		sens2 = 0;
		if (t < TEMP_REF) begin
			t2 = (dt * dt) >>> 31;
			dtemp = (t - TEMP_REF) * (t - TEMP_REF);
			off2 = (5 * dtemp) >>> 1;
			sens2 = (5 * dtemp) >>> 2;
			if (t < COLD_LIMIT) begin
				cold = (t - COLD_LIMIT) * (t - COLD_LIMIT);
				off2 += 7 * cold;
				sens2 += (11 * cold) >>> 1;
			end
		end
		t -= t2;
		off -= off2;
		sens -= sens2;
		p = (((d1 * sens) >>> P_SHIFT) + off) >>> PRES_SHIFT;
		if (p > PRES_MAX)
			p = PRES_MAX;
		if (p < PRES_MIN)
			p = PRES_MIN;
		r.pressure = p[PRES_W-1:0];
		r.temperature = t[TEMP_W-1:0];
		return r;
	endfunction

	function automatic logic [CAL_W-1:0] pick_word();
		int k;
		k = $urandom_range(0, 5);
		if (k == 0)
			return '0;
		if (k == 1)
			return '1;
		return CAL_W'($urandom());
	endfunction

	function automatic longint clamp_raw(input longint v);
		if (v < 0)
			return 0;
		if (v > RAW_MAX)
			return RAW_MAX;
		return v;
	endfunction

	task automatic queue_sample(input longint d1, input longint d2);
		sample_t s;
		s.d1 = RAW_PORT_W'(clamp_raw(d1));
		s.d2 = RAW_PORT_W'(clamp_raw(d2));
		pending_samples.push_back(s);
	endtask

	// raw temperatures around the 20 degC and -15 degC decision points
	task automatic queue_temp_edges(input longint d1);
		longint ref_code, warm_span, cold_span;
		ref_code = longint'(cal.c5) << C5_SHIFT;
		warm_span = (cal.c6 == 0) ? 1 : TDIV / longint'(cal.c6);
		cold_span = (cal.c6 == 0) ? 2 : ((TEMP_REF - COLD_LIMIT) * TDIV) / longint'(cal.c6);
		queue_sample(d1, ref_code);
		queue_sample(d1, ref_code - 1);
		queue_sample(d1, ref_code - warm_span);
		queue_sample(d1, ref_code - warm_span - 1);
		queue_sample(d1, ref_code - cold_span + 1);
		queue_sample(d1, ref_code - cold_span);
		queue_sample(d1, ref_code - cold_span - 1);
	endtask

	task automatic queue_random_samples(input int n);
		int k;
		longint d1, d2, ref_code;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			ref_code = longint'(cal.c5) << C5_SHIFT;
			d1 = $urandom_range(0, 32'(RAW_MAX));
			d2 = $urandom_range(0, 32'(RAW_MAX));
			if (k < 4) begin
				if (k[0])
					d1 = 0;
				if (k[1] || !k[0])
					d2 = 0;
			end else if (k < 10) begin
				d1 = k[0] ? RAW_MAX : 1;
				d2 = k[1] ? RAW_MAX : 1;
			end else if (k < 30) begin
				d2 = ref_code + $urandom_range(0, 4096) - 2048;
			end else if (k < 45 && ref_code > 1) begin
				d2 = $urandom_range(1, 32'(ref_code));
			end
			queue_sample(d1 == 0 && k >= 4 ? 1 : d1, d2 == 0 && k >= 4 ? 1 : d2);
		end
	endtask

	task automatic write_cal(input logic [IDX_W-1:0] idx, input logic [CAL_W-1:0] word);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_W'(idx) << ADDR_LSB;
		// upper data bits carry noise, only the low word is kept
		pwdata <= {16'($urandom()), word};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_C1: cal.c1 = word;
			REG_C2: cal.c2 = word;
			REG_C3: cal.c3 = word;
			REG_C4: cal.c4 = word;
			REG_C5: cal.c5 = word;
			REG_C6: cal.c6 = word;
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic load_calibration(input cal_t c);
		write_cal(REG_C1, c.c1);
		write_cal(REG_C2, c.c2);
		write_cal(REG_C3, c.c3);
		write_cal(REG_C4, c.c4);
		write_cal(REG_C5, c.c5);
		write_cal(REG_C6, c.c6);
		n_cal_sets++;
	endtask

	task automatic drain();
		while (pending_samples.size() != 0 || sample_valid || expected_readings.size() != 0)
			@(negedge clk);
		repeat (PIPE_DEPTH + 2) @(negedge clk);
	endtask

	// sender: new sample at the falling edge, held until taken
	always @(negedge clk) begin
		if (sample_valid && !in_fire) begin
		end else if (src_gap > 0) begin
			src_gap--;
			sample_valid <= 1'b0;
		end else if (pending_samples.size() != 0 && idle_enable && $urandom_range(0, 5) == 0) begin
			src_gap = $urandom_range(0, 3);
			sample_valid <= 1'b0;
		end else if (pending_samples.size() != 0) begin
			next_sample = pending_samples.pop_front();
			sample_valid <= 1'b1;
			raw_pressure <= next_sample.d1;
			raw_temperature <= next_sample.d2;
		end else begin
			sample_valid <= 1'b0;
		end
	end

	// receiver: random stall bursts plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap--;
			result_ready <= 1'b0;
		end else if (idle_enable && $urandom_range(0, 4) == 0) begin
			sink_gap = $urandom_range(0, 3);
			result_ready <= 1'b0;
		end else begin
			result_ready <= arst_n;
		end
	end

	always @(posedge clk) begin
		in_fire = sample_valid && sample_ready;
		out_fire = result_valid && result_ready;
		if (in_fire)
			expected_readings.push_back(compensate(raw_pressure, raw_temperature));
		if (out_fire) begin
			got.pressure = pressure_centi_mbar;
			got.temperature = temperature_centi_c;
			got.status = status;
			if (expected_readings.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: p=%0d t=%0d st=%0b",
						got.pressure, got.temperature, got.status);
			end else begin
				want = expected_readings.pop_front();
				n_checked++;
				if (want.status)
					n_zero++;
				if (want.temperature < COLD_LIMIT)
					n_cold++;
				if (got.pressure !== want.pressure || got.temperature !== want.temperature ||
						got.status !== want.status) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected p=%0d t=%0d st=%0b, got p=%0d t=%0d st=%0b",
							want.pressure, want.temperature, want.status,
							got.pressure, got.temperature, got.status);
				end
			end
		end
		if (in_fire || out_fire || (psel && penable && pwrite && pready))
			quiet_cycles = 0;
		else if (arst_n)
			quiet_cycles++;
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		cal_t c;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// calibration words still at reset values
		queue_sample(1, 1);
		queue_sample(RAW_MAX, RAW_MAX);
		queue_sample(0, RAW_MAX);
		queue_sample(RAW_MAX, 0);
		drain();

		// typical factory calibration
		c = '{c1: 16'd40127, c2: 16'd36924, c3: 16'd23317, c4: 16'd23282,
			c5: 16'd33464, c6: 16'd28312};
		load_calibration(c);
		queue_sample(9085466, 8569150);
		queue_sample(0, 8569150);
		queue_sample(9085466, 0);
		queue_sample(0, 0);
		queue_sample(RAW_MAX, 1);
		queue_sample(RAW_MAX, RAW_MAX);
		queue_temp_edges(RAW_MAX);
		drain();

		// writes to unused addresses must not disturb the calibration
		write_cal(REG_SPARE0, CAL_W'($urandom()));
		write_cal(REG_SPARE1, CAL_W'($urandom()));
		queue_sample(9085466, 8569150);
		drain();

		c = '{c1: '1, c2: '1, c3: '1, c4: '1, c5: '1, c6: '1};
		load_calibration(c);
		queue_sample(RAW_MAX, 1);
		queue_sample(1, RAW_MAX);
		queue_temp_edges(RAW_MAX);
		drain();

		for (int set = 0; set < RANDOM_SETS; set++) begin
			c.c1 = pick_word();
			c.c2 = pick_word();
			c.c3 = pick_word();
			c.c4 = pick_word();
			c.c5 = pick_word();
			c.c6 = pick_word();
			if (set == 0) begin
				c.c5 = '1;
				c.c6 = '1;
			end else if (set == 1) begin
				c.c5 = '0;
				c.c6 = '1;
			end
			load_calibration(c);
			idle_enable = (set < RANDOM_SETS - 2);
			queue_random_samples(SET_SAMPLES);
			if (set == 3) begin
				// stall the result side long enough to back the pipeline up
				@(posedge clk);
				hold_request = LONG_HOLD;
			end
			drain();
		end

		$display("checked %0d readings across %0d calibration sets", n_checked, n_cal_sets);
		$display("%0d zero-reading results, %0d below -15 degC, one %0d-cycle result stall",
			n_zero, n_cold, LONG_HOLD);
		if (errors == 0 && expected_readings.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: files.f
+incdir+hdl
hdl/bptc_pkg.sv
hdl/bptc_cfg_regs.sv
hdl/bptc_pipe_ctrl.sv
hdl/bptc_temp_path.sv
hdl/bptc_press_path.sv
hdl/baro_pressure_temp_compensation.sv
tb/tb_baro_pressure_temp_compensation.sv
